// File: design/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and code functions of the 3x3 texture code block.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MIN_DIM       = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PIXEL_W       = 8;
    localparam int ROW_W         = 16;
    localparam int FWIDTH_W      = 12;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CODE_MODE    = 2'd2;

    localparam logic [3:0] NONUNIFORM_BIN = 4'd9;
    localparam logic [7:0] BIN_SCALE      = 8'd10;

    typedef struct packed {
        logic [7:0] pattern;
        logic       frame_done;
    } t_pat_entry;

    function automatic logic [7:0] uniform_code(input logic [7:0] pat);
        logic [3:0] ones;
        logic [3:0] trans;
        logic [3:0] bin;
        ones  = '0;
        trans = '0;
        for (int i = 0; i < 8; i++) begin
            ones  = ones + 4'(pat[i]);
            trans = trans + 4'(pat[i] ^ pat[(i + 1) % 8]);
        end
        bin = (trans > 4'd2) ? NONUNIFORM_BIN : ones;
        return 8'(8'(bin) * BIN_SCALE);
    endfunction

    function automatic logic [7:0] min_rotation(input logic [7:0] pat);
        logic [7:0] best;
        logic [7:0] rot;
        best = pat;
        for (int i = 1; i < 8; i++) begin
            rot = 8'((pat << i) | (pat >> (8 - i)));
            if (rot < best) begin
                best = rot;
            end
        end
        return best;
    endfunction

endpackage

// File: design/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ltc_front.sv
// ----------------------------------------------------------------------------
// ltc_front
// Pixel intake: position counters, line buffers, 3x3 window and neighbor
// pattern for interior centers.
// ----------------------------------------------------------------------------
module ltc_front #(
    parameter int MAX_WIDTH = ltc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [ltc_pkg::PIXEL_W-1:0]         i_pixel,
    input  logic [ltc_pkg::FWIDTH_W-1:0]        i_frame_width,
    input  logic [ltc_pkg::ROW_W-1:0]           i_frame_height,
    input  logic [$clog2(ltc_pkg::QUEUE_DEPTH+1)-1:0] i_q_level,
    output logic                                o_q_push,
    output ltc_pkg::t_pat_entry                 o_q_entry
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = (CB + 1 > ltc_pkg::FWIDTH_W) ? CB + 1 : ltc_pkg::FWIDTH_W;
    localparam int LW = $clog2(ltc_pkg::QUEUE_DEPTH + 1);
    localparam int PW = ltc_pkg::PIXEL_W;
    localparam int RW = ltc_pkg::ROW_W;

    logic [CB-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic          r_a_valid;
    logic          r_a_inside;
    logic          r_a_emit;
    logic          r_a_last;
    logic [CB-1:0] r_a_col;
    logic [PW-1:0] r_a_pixel;

    logic [PW-1:0] r_top1, r_top2, r_mid1, r_mid2, r_bot1, r_bot2;

    logic [WB-1:0] fw_ext, w_eff, w_last, col_ext;
    logic [RW-1:0] h_eff, h_last;
    logic          accept;
    logic          in_frame, emit, last;
    logic [PW-1:0] top, mid;
    logic [7:0]    pattern;
    logic          wr_en;

    always_comb begin
        fw_ext = WB'(i_frame_width);
        if (fw_ext < WB'(ltc_pkg::MIN_DIM)) begin
            w_eff = WB'(ltc_pkg::MIN_DIM);
        end else if (fw_ext > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        w_last = w_eff - WB'(1);
        h_eff  = (i_frame_height < RW'(ltc_pkg::MIN_DIM)) ? RW'(ltc_pkg::MIN_DIM)
                                                          : i_frame_height;
        h_last = h_eff - RW'(1);
    end

    assign o_full = ((LW + 1)'(i_q_level) + (LW + 1)'(r_a_valid))
                    >= (LW + 1)'(ltc_pkg::QUEUE_DEPTH);
    assign accept = i_push && !o_full;

    always_comb begin
        col_ext  = WB'(r_col);
        in_frame = (col_ext <= w_last) && (r_row <= h_last);
        emit     = in_frame && (r_col >= CB'(2)) && (r_row >= RW'(2));
        last     = (col_ext == w_last) && (r_row == h_last);
        if (col_ext >= w_last) begin
            n_col = '0;
            n_row = (r_row >= h_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CB'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_inside <= in_frame;
            r_a_emit   <= emit;
            r_a_last   <= last;
            r_a_col    <= r_col;
            r_a_pixel  <= i_pixel;
        end
    end

    assign wr_en = r_a_valid && r_a_inside;

    ltc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_a_col),
        .i_wdata (mid),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (top)
    );

    ltc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pixel),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mid)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_top2 <= r_top1;
            r_top1 <= top;
            r_mid2 <= r_mid1;
            r_mid1 <= mid;
            r_bot2 <= r_bot1;
            r_bot1 <= r_a_pixel;
        end
    end

    always_comb begin
        pattern[7] = r_top2    >= r_mid1;
        pattern[6] = r_top1    >= r_mid1;
        pattern[5] = top       >= r_mid1;
        pattern[4] = mid       >= r_mid1;
        pattern[3] = r_a_pixel >= r_mid1;
        pattern[2] = r_bot1    >= r_mid1;
        pattern[1] = r_bot2    >= r_mid1;
        pattern[0] = r_mid2    >= r_mid1;
    end

    assign o_q_push             = r_a_valid && r_a_emit;
    assign o_q_entry.pattern    = pattern;
    assign o_q_entry.frame_done = r_a_last;

endmodule

// File: design/ltc_queue.sv
// ----------------------------------------------------------------------------
// ltc_queue
// Short FIFO of neighbor patterns between intake and code stage.
// ----------------------------------------------------------------------------
module ltc_queue (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  ltc_pkg::t_pat_entry                       i_entry,
    input  logic                                      i_pop,
    output logic                                      o_valid,
    output ltc_pkg::t_pat_entry                       o_entry,
    output logic [$clog2(ltc_pkg::QUEUE_DEPTH+1)-1:0] o_level
);

    localparam int QD = ltc_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(QD);
    localparam int LW = $clog2(QD + 1);

    ltc_pkg::t_pat_entry r_mem [QD];
    logic [AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [LW-1:0]       r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QD - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QD - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LW'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign o_level = r_level;

endmodule

// File: design/ltc_back.sv
// ----------------------------------------------------------------------------
// ltc_back
// Code stage: turns a neighbor pattern into the selected texture code and
// holds it in the result register.
// ----------------------------------------------------------------------------
module ltc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ltc_pkg::t_pat_entry i_q_entry,
    output logic                o_q_pop,
    input  logic                i_code_mode,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_texture_code,
    output logic                o_frame_done
);

    logic       r_out_valid;
    logic [7:0] r_code;
    logic       r_done;
    logic [7:0] n_code;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_pop);

    always_comb begin
        if (i_code_mode) begin
            n_code = ltc_pkg::min_rotation(i_q_entry.pattern);
        end else begin
            n_code = ltc_pkg::uniform_code(i_q_entry.pattern);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_code <= n_code;
            r_done <= i_q_entry.frame_done;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_texture_code = r_code;
    assign o_frame_done   = r_done;

endmodule

// File: design/lbp_texture_code_3x3_top.sv
// ----------------------------------------------------------------------------
// lbp_texture_code_3x3_top
// 3x3 local binary pattern over a raster grayscale stream, one code per
// interior pixel.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------
//  pixel     | in        | push / full                    | i_pixel
//  result    | out       | pop / empty                    | o_texture_code, o_frame_done
//  config    | in        | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
//  One pixel per clock while full is low; a pixel is registered at intake,
//  its pattern then passes the pattern FIFO into the result register.
//  Reset is synchronous; line buffers are not cleared, every entry is
//  written one row before it is read.
//  full rises while the pattern FIFO plus the pixel in flight fill its four
//  slots; a stalled result side backs up into full after that.
// ----------------------------------------------------------------------------
module lbp_texture_code_3x3_top #(
    parameter int MAX_WIDTH = ltc_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ltc_pkg::PIXEL_W-1:0]       i_pixel,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_texture_code,
    output logic                              o_frame_done,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ltc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ltc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ltc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int LW = $clog2(ltc_pkg::QUEUE_DEPTH + 1);
    localparam int DW = ltc_pkg::APB_DATA_W;

    logic [ltc_pkg::FWIDTH_W-1:0] r_frame_width;
    logic [ltc_pkg::ROW_W-1:0]    r_frame_height;
    logic                         r_code_mode;

    logic                cfg_wr;
    logic [1:0]          reg_idx;
    logic                q_push, q_pop, q_valid;
    ltc_pkg::t_pat_entry q_in, q_head;
    logic [LW-1:0]       q_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ltc_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ltc_pkg::FWIDTH_W'(640);
            r_frame_height <= ltc_pkg::ROW_W'(480);
            r_code_mode    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ltc_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[ltc_pkg::FWIDTH_W-1:0];
                ltc_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[ltc_pkg::ROW_W-1:0];
                ltc_pkg::REG_CODE_MODE:    r_code_mode    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ltc_pkg::REG_FRAME_WIDTH:  prdata = DW'(r_frame_width);
            ltc_pkg::REG_FRAME_HEIGHT: prdata = DW'(r_frame_height);
            ltc_pkg::REG_CODE_MODE:    prdata = DW'(r_code_mode);
            default:                   prdata = '0;
        endcase
    end

    ltc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_pixel        (i_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_level      (q_level),
        .o_q_push       (q_push),
        .o_q_entry      (q_in)
    );

    ltc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_head),
        .o_level (q_level)
    );

    ltc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_head),
        .o_q_pop        (q_pop),
        .i_code_mode    (r_code_mode),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_texture_code (o_texture_code),
        .o_frame_done   (o_frame_done)
    );

endmodule

// File: verif/lbp_texture_code_3x3_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbp_texture_code_3x3_top_tb
// Self-checking bench for the 3x3 local binary pattern stream block.
// A directed checkerboard frame with hand-computed codes in both code modes
// comes first, then random frames of small size with varied pixel texture,
// a tall frame and two full-width frames cut short by shrinking the size
// mid-frame. Other codes are compared against a cycle-free pixel predictor.
// Both sides idle at random; the result side also holds off long enough to
// back the block up into its input.
// ----------------------------------------------------------------------------
module lbp_texture_code_3x3_top_tb;
    import ltc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SHAPED_ITEMS  = 1050;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned MAX_PRINTS    = 40;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam logic [7:0] PIX_MIN      = 8'h00;
    localparam logic [7:0] PIX_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0] code;
        logic       done;
    } t_code_beat;

    typedef struct packed {
        logic       to_mode1;
        logic       pinned;
        logic [7:0] value;
        logic [7:0] code;
        logic       done;
    } t_probe_row;

    typedef enum logic [1:0] {
        FILL_NOISE,
        FILL_FLAT,
        FILL_TWO_LEVEL,
        FILL_RAMP
    } t_fill;

    // 4x4 checkerboard; centre codes read off by hand
    localparam t_probe_row CHECKER_ROWS [16] = '{
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b1, PIX_MIN, 8'd80,  1'b0},
        '{1'b0, 1'b1, PIX_MAX, 8'd90,  1'b0},
        '{1'b0, 1'b0, PIX_MAX, 8'd0,   1'b0},
        '{1'b0, 1'b0, PIX_MIN, 8'd0,   1'b0},
        '{1'b1, 1'b1, PIX_MAX, 8'd85,  1'b0},
        '{1'b0, 1'b1, PIX_MIN, 8'd255, 1'b1}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    logic [PIXEL_W-1:0]    i_pixel = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    logic [7:0]            o_texture_code;
    logic                  o_frame_done;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [7:0]      upper_line [MAX_WIDTH_DEF];
    logic [7:0]      middle_line [MAX_WIDTH_DEF];
    logic [7:0]      win [6];
    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    logic [11:0]     cfg_width  = 12'd640;
    logic [15:0]     cfg_height = 16'd480;
    logic            cfg_mode   = 1'b0;
    t_code_beat      pending_codes [$];
    t_code_beat      pinned_codes [int unsigned];
    int unsigned     pix_seq = 0;

    int unsigned     pixels_sent   = 0;
    int unsigned     codes_checked = 0;
    int unsigned     frames_run    = 0;
    int unsigned     error_count   = 0;
    int unsigned     burst_left    = 0;
    int unsigned     hold_asks     = 0;
    int unsigned     hold_seen     = 0;

    lbp_texture_code_3x3_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_pixel        (i_pixel),
        .empty          (empty),
        .pop            (pop),
        .o_texture_code (o_texture_code),
        .o_frame_done   (o_frame_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string what);
        if (error_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic int unsigned eff_width(input logic [11:0] w);
        if (w < MIN_DIM) return MIN_DIM;
        if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned eff_height(input logic [15:0] h);
        return (h < MIN_DIM) ? MIN_DIM : h;
    endfunction

    function automatic logic [7:0] uniform_x10(input logic [7:0] pat);
        int unsigned flips;
        flips = $countones(pat ^ {pat[0], pat[7:1]});
        if (flips > 2) return 8'(NONUNIFORM_BIN * BIN_SCALE);
        return 8'($countones(pat) * BIN_SCALE);
    endfunction

    function automatic logic [7:0] min_rot_code(input logic [7:0] pat);
        logic [7:0] spun;
        logic [7:0] least;
        spun  = pat;
        least = pat;
        repeat (7) begin
            spun = {spun[6:0], spun[7]};
            if (spun < least) least = spun;
        end
        return least;
    endfunction

    // advance the window by one pixel; returns 1 when a centre is complete
    function automatic bit slide_window(input logic [7:0] px, output t_code_beat res);
        int unsigned ew;
        int unsigned eh;
        logic [7:0]  above;
        logic [7:0]  middle;
        logic [7:0]  ctr;
        logic [7:0]  pat;
        bit          produced;
        produced = 1'b0;
        res      = '0;
        ew       = eff_width(cfg_width);
        eh       = eff_height(cfg_height);
        if (col_pos < ew && row_pos < eh) begin
            above  = upper_line[col_pos];
            middle = middle_line[col_pos];
            if (col_pos >= 2 && row_pos >= 2) begin
                ctr = win[2];
                pat = {win[1] >= ctr, win[0] >= ctr, above >= ctr, middle >= ctr,
                       px >= ctr, win[4] >= ctr, win[5] >= ctr, win[3] >= ctr};
                res.code = cfg_mode ? min_rot_code(pat) : uniform_x10(pat);
                res.done = (col_pos == ew - 1 && row_pos == eh - 1);
                produced = 1'b1;
            end
            win[1] = win[0];
            win[0] = above;
            win[3] = win[2];
            win[2] = middle;
            win[5] = win[4];
            win[4] = px;
            upper_line[col_pos]  = middle;
            middle_line[col_pos] = px;
        end
        if (col_pos + 1 >= ew) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return produced;
    endfunction

    always @(posedge i_clk) begin
        t_code_beat got;
        t_code_beat want;
        if (!i_rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            cfg_width  = 12'd640;
            cfg_height = 16'd480;
            cfg_mode   = 1'b0;
            pix_seq    = 0;
            for (int k = 0; k < 6; k++) win[k] = '0;
            pending_codes.delete();
        end else begin
            if (pop && !empty) begin
                got = {o_texture_code, o_frame_done};
                if (pending_codes.size() == 0) begin
                    flag_error($sformatf("code %0d arrived with nothing pending", got.code));
                end else begin
                    want = pending_codes.pop_front();
                    codes_checked++;
                    if (got.code !== want.code) begin
                        flag_error($sformatf("texture_code %0d, want %0d", got.code, want.code));
                    end
                    if (got.done !== want.done) begin
                        flag_error($sformatf("frame_done %b, want %b", got.done, want.done));
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FRAME_WIDTH:  cfg_width  = pwdata[FWIDTH_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height = pwdata[ROW_W-1:0];
                    REG_CODE_MODE:    cfg_mode   = pwdata[0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                if (slide_window(i_pixel, want)) begin
                    if (pinned_codes.exists(pix_seq)) want = pinned_codes[pix_seq];
                    pending_codes.push_back(want);
                end
                pix_seq++;
            end
        end
    end

    // result side: random stall patterns, plus a long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned phase_left;
        logic [15:0] stall_mask;
        hold_left  = 0;
        phase_left = 0;
        stall_mask = '1;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(16, 96);
                    stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                end
                phase_left--;
                pop <= stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[15:1]};
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d codes still pending",
                 CYCLE_LIMIT, pending_codes.size());
        $display("lbp_texture_code_3x3_top regression: fail");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] value);
        int unsigned gap;
        if (!push) push <= 1'b1;
        i_pixel <= value;
        do @(posedge i_clk); while (full);
        pixels_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 16);
        end
    endtask

    // drop push, wait for every pending code, then let the pipeline empty
    task automatic settle_block();
        if (push) push <= 1'b0;
        @(posedge i_clk);
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // on a read, value is the expected register content
    task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr ? value : 32'h0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata !== value) begin
            flag_error($sformatf("register %0d reads %0h, want %0h", idx, prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] with_junk(input logic [31:0] value, input int kept);
        logic [31:0] mask;
        mask = (32'd1 << kept) - 32'd1;
        if ($urandom_range(0, 1) != 0) return (value & mask) | ($urandom & ~mask);
        return value;
    endfunction

    function automatic logic [7:0] texture_pixel(input t_fill fill, input int unsigned r,
                                                  input int unsigned c, input logic [7:0] base,
                                                  input logic [7:0] alt);
        case (fill)
            FILL_FLAT:      return 8'(base + $urandom_range(0, 2));
            FILL_TWO_LEVEL: return ($urandom_range(0, 1) != 0) ? base : alt;
            FILL_RAMP:      return 8'(base + r * alt + c * 3) ^
                                   (($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
            default:        return 8'($urandom);
        endcase
    endfunction

    task automatic run_frame(input logic [31:0] w_val, input logic [31:0] h_val,
                             input bit hold);
        int unsigned ew;
        int unsigned eh;
        int unsigned flip_at;
        logic [1:0]  peek;
        logic [31:0] shadow;
        t_fill       fill;
        logic [7:0]  base;
        logic [7:0]  alt;
        settle_block();
        reg_access(1'b1, REG_FRAME_WIDTH, with_junk(w_val, FWIDTH_W));
        reg_access(1'b1, REG_FRAME_HEIGHT, with_junk(h_val, ROW_W));
        reg_access(1'b1, REG_CODE_MODE, with_junk(32'($urandom_range(0, 1)), 1));
        if ($urandom_range(0, 7) == 0) reg_access(1'b1, REG_UNMAPPED, $urandom);
        peek = 2'($urandom_range(0, 2));
        case (peek)
            REG_FRAME_WIDTH:  shadow = {20'h0, cfg_width};
            REG_FRAME_HEIGHT: shadow = {16'h0, cfg_height};
            default:          shadow = {31'h0, cfg_mode};
        endcase
        reg_access(1'b0, peek, shadow);
        ew      = eff_width(w_val[11:0]);
        eh      = eff_height(h_val[15:0]);
        flip_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, ew * eh - 1) : 0;
        fill    = t_fill'($urandom_range(0, 3));
        base    = 8'($urandom);
        alt     = 8'($urandom);
        if (hold) hold_asks++;
        for (int unsigned n = 0; n < ew * eh; n++) begin
            if (flip_at != 0 && n == flip_at) begin
                settle_block();
                reg_access(1'b1, REG_CODE_MODE, {31'h0, ~cfg_mode});
            end
            send_pixel(texture_pixel(fill, n / ew, n % ew, base, alt));
        end
        frames_run++;
    endtask

    // frame of the given height setting; shrink to 6 rows at row 10
    task automatic tall_then_cut(input logic [31:0] h_val);
        int unsigned ew;
        settle_block();
        ew = $urandom_range(4, 6);
        reg_access(1'b1, REG_FRAME_WIDTH, ew);
        reg_access(1'b1, REG_FRAME_HEIGHT, with_junk(h_val, ROW_W));
        reg_access(1'b1, REG_CODE_MODE, $urandom_range(0, 1));
        reg_access(1'b0, REG_FRAME_HEIGHT, {16'h0, cfg_height});
        repeat (10 * ew) send_pixel(8'($urandom));
        settle_block();
        reg_access(1'b1, REG_FRAME_HEIGHT, 32'd6);
        repeat (ew) send_pixel(8'($urandom));
        frames_run++;
    endtask

    // part of row zero at the given width, then shrink the width inside it
    // and finish three narrow rows
    task automatic wide_then_cut(input logic [31:0] w_val);
        int unsigned ew;
        int unsigned cut;
        int unsigned narrow;
        t_fill       fill;
        logic [7:0]  base;
        logic [7:0]  alt;
        settle_block();
        reg_access(1'b1, REG_FRAME_WIDTH, w_val);
        reg_access(1'b1, REG_FRAME_HEIGHT, $urandom_range(0, 4));
        reg_access(1'b1, REG_CODE_MODE, $urandom_range(0, 1));
        reg_access(1'b0, REG_FRAME_WIDTH, {20'h0, cfg_width});
        ew     = eff_width(w_val[11:0]);
        cut    = $urandom_range(100, 300);
        narrow = $urandom_range(4, 8);
        fill   = t_fill'($urandom_range(0, 3));
        base   = 8'($urandom);
        alt    = 8'($urandom);
        for (int unsigned n = 0; n < cut; n++) begin
            send_pixel(texture_pixel(fill, n / ew, n % ew, base, alt));
        end
        settle_block();
        reg_access(1'b1, REG_FRAME_WIDTH, narrow);
        send_pixel(8'($urandom));
        for (int unsigned n = 0; n < 3 * narrow; n++) begin
            send_pixel(texture_pixel(fill, 1 + n / narrow, n % narrow, base, alt));
        end
        frames_run++;
    endtask

    initial begin : stimulus
        int unsigned frame_no;
        int unsigned pick;
        logic [31:0] w_val;
        logic [31:0] h_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_access(1'b0, REG_FRAME_WIDTH, 32'd640);
        reg_access(1'b0, REG_FRAME_HEIGHT, 32'd480);
        reg_access(1'b0, REG_CODE_MODE, 32'd0);
        reg_access(1'b1, REG_FRAME_WIDTH, 32'd4);
        reg_access(1'b1, REG_FRAME_HEIGHT, 32'd4);
        reg_access(1'b1, REG_CODE_MODE, 32'd0);
        reg_access(1'b1, REG_UNMAPPED, 32'hFFFF_FFFF);
        reg_access(1'b0, REG_FRAME_WIDTH, 32'd4);
        reg_access(1'b0, REG_CODE_MODE, 32'd0);

        foreach (CHECKER_ROWS[i]) begin
            if (CHECKER_ROWS[i].to_mode1) begin
                settle_block();
                reg_access(1'b1, REG_CODE_MODE, 32'd1);
            end
            if (CHECKER_ROWS[i].pinned) begin
                pinned_codes[pixels_sent] = {CHECKER_ROWS[i].code, CHECKER_ROWS[i].done};
            end
            send_pixel(CHECKER_ROWS[i].value);
        end
        frames_run++;

        frame_no = 0;
        while (pixels_sent < SHAPED_ITEMS || frame_no < 10) begin
            case (frame_no)
                0: run_frame(32'd12, 32'd8, 1'b1);
                3: tall_then_cut(32'hFFFF);
                6: wide_then_cut(32'd2048);
                9: wide_then_cut(32'hFFF);
                default: begin
                    pick  = $urandom_range(0, 9);
                    w_val = (pick == 0) ? $urandom_range(0, 3) :
                            (pick == 1) ? $urandom_range(13, 24) : $urandom_range(4, 12);
                    pick  = $urandom_range(0, 9);
                    h_val = (pick == 0) ? $urandom_range(0, 3) :
                            (pick == 1) ? $urandom_range(9, 12) : $urandom_range(4, 8);
                    run_frame(w_val, h_val, 1'b0);
                end
            endcase
            frame_no++;
        end

        settle_block();
        $display("covered %0d pixels in %0d frames, %0d texture codes checked,",
                 pixels_sent, frames_run, codes_checked);
        $display("widths 4 to 2048, heights 4 to 65535, both code modes, mid-frame writes");
        if (error_count == 0) begin
            $display("lbp_texture_code_3x3_top regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("lbp_texture_code_3x3_top regression: fail");
        end
        $finish;
    end

endmodule
